// File: hw/rtl/cbe_pkg.sv
// Shared types, constants and the sample-point table for the cubic Bezier easing unit.
// Used by cbe_qmul, cbe_div, cubic_bezier_easing_unit and the testbench. No dependencies.
`timescale 1ns / 1ps

package cbe_pkg;

   // Fixed-point format of all internal values. Q16 fields map onto it one to one.
   localparam int FRAC_BITS        = 16;
   localparam int SAMPLE_COUNT     = 11;
   localparam int NEWTON_STEPS_DEF = 4;
   localparam int BISECT_STEPS_DEF = 10;

   // Field widths.
   localparam int XW     = 17;           // progress and x control points
   localparam int YW     = 20;           // y control points and eased value
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 20;
   localparam int REQ_TW = 24;
   localparam int RSP_TW = 24;

   // Datapath widths.
   localparam int DW   = 48;             // accumulator and dividend
   localparam int TW   = 20;             // curve parameter t, +-4.0
   localparam int MAW  = 32;             // multiplier operand a
   localparam int CW   = 24;             // polynomial coefficients
   localparam int DVW  = 32;             // divisor
   localparam int QB   = 21;             // quotient bits developed by the divider
   localparam int QW   = QB + 2;         // signed, saturated quotient
   localparam int SIW  = $clog2(SAMPLE_COUNT);

   localparam longint ONE_Q       = 64'sd1 <<< FRAC_BITS;
   localparam longint MIN_SLOPE_Q = (ONE_Q + 500) / 1000;
   localparam longint PRECISION_Q = (ONE_Q + 5000000) / 10000000;
   localparam longint T_LIM       = 4 * ONE_Q;
   localparam longint DIST_LIM    = 4 * ONE_Q;
   localparam longint CORR_LIM    = 8 * ONE_Q;
   localparam longint Y_LIM       = 262144;
   localparam longint ONE_PROG    = 65536;

   // Reciprocal of the sample spacing count, exact for magnitudes up to DIST_LIM.
   localparam int     SEG_SHIFT = 23;
   localparam longint SEG_RECIP = ((64'sd1 <<< SEG_SHIFT) + SAMPLE_COUNT - 2)
                                  / (SAMPLE_COUNT - 1);

   typedef logic signed [DW-1:0] dw_type;
   typedef logic signed [TW-1:0] t_type;
   typedef logic [SAMPLE_COUNT-1:0][TW-1:0] tab_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_X1 = 2'd0,
      CSR_Y1 = 2'd1,
      CSR_X2 = 2'd2,
      CSR_Y2 = 2'd3
   } csr_index_type;

   // Sample points i/(SAMPLE_COUNT-1), rounded to the nearest LSB.
   function automatic tab_type build_sample_t();
      tab_type tab;
      longint  v;
      int      i;
      for (i = 0; i < SAMPLE_COUNT; i++) begin
         v = (longint'(i) * ONE_Q + (SAMPLE_COUNT - 1) / 2) / (SAMPLE_COUNT - 1);
         tab[i] = v[TW-1:0];
      end
      return tab;
   endfunction

   localparam tab_type SAMPLE_T = build_sample_t();

endpackage

// File: hw/rtl/cbe_qmul.sv
// Shared two-stage fixed-point multiplier: product, then shift back by FRAC_BITS
// rounding half away from zero. Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_qmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [cbe_pkg::MAW-1:0] op_a,
   input  logic signed [cbe_pkg::TW-1:0]  op_b,
   output logic                           busy,
   output logic                           done,
   output cbe_pkg::dw_type                result
);
   import cbe_pkg::*;

   localparam int PW = MAW + TW;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic                 prod_vld_ff;
   logic [PW-1:0]        mag;
   logic [PW-1:0]        rmag;
   logic signed [PW-1:0] rounded;
   dw_type               result_ff;
   logic                 done_ff;

   always_comb begin
      prod_in = PW'(op_a) * PW'(op_b);
      mag     = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      rmag    = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      rounded = prod_ff[PW-1] ? -$signed(rmag) : $signed(rmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         prod_vld_ff <= start;
         done_ff     <= prod_vld_ff;
      end
      prod_ff <= prod_in;
      if (prod_vld_ff) begin
         result_ff <= DW'(rounded);
      end
   end

   assign busy   = prod_vld_ff | done_ff;
   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: hw/rtl/cbe_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero. Quotients
// too large for QB bits saturate, which every caller clamps anyway. Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  cbe_pkg::dw_type                num,
   input  logic signed [cbe_pkg::DVW-1:0] den,
   output logic                           done,
   output logic signed [cbe_pkg::QW-1:0]  quo
);
   import cbe_pkg::*;

   localparam int RW  = DVW + QB;
   localparam int CNW = $clog2(QB + 1);

   logic [RW-1:0]  rem_ff;
   logic [RW-1:0]  sh_ff;
   logic [QB-1:0]  q_ff;
   logic [CNW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic           neg_ff;
   logic           ovf_ff;
   logic [DW-1:0]  num_mag;
   logic [DVW-1:0] den_mag;
   logic           fits;
   logic [QB:0]    qmag;

   always_comb begin
      num_mag = num[DW-1] ? DW'(-num) : DW'(num);
      den_mag = den[DVW-1] ? DVW'(-den) : DVW'(den);
      fits    = rem_ff >= sh_ff;
      qmag    = ovf_ff ? (QB+1)'(1) << QB : {1'b0, q_ff};
      quo     = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNW'(QB);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff <= RW'(num_mag);
         sh_ff  <= RW'(den_mag) << (QB - 1);
         ovf_ff <= RW'(num_mag) >= (RW'(den_mag) << QB);
         neg_ff <= num[DW-1] ^ den[DVW-1];
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - sh_ff;
         end
         q_ff  <= {q_ff[QB-2:0], fits};
         sh_ff <= sh_ff >> 1;
      end
   end

   assign done = done_ff;

endmodule

// File: hw/rtl/cubic_bezier_easing_unit.sv
// Top level of the cubic Bezier easing unit: configuration, sample table and the
// sequencer around the shared multiplier and divider. Depends on cbe_pkg, cbe_qmul, cbe_div.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tdata[16:0] progress
//  rsp     | out       | rsp_tvalid/tready  | tdata[19:0] eased
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
// One request is quickest for end points or a linear curve, which bypass the search, and
// slowest for a table walk to the last entry and four Newton steps. Each curve or slope
// evaluation is three passes through the multiplier; each division runs on the bit-serial
// divider. The guess step from the fraction is a reciprocal multiply.
// Reset and every register write rebuild the sample table: 11 curve evaluations,
// with req_tready low. A stalled response holds in its register.

module cubic_bezier_easing_unit #(
   parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
   parameter int BISECT_STEPS = cbe_pkg::BISECT_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cbe_pkg::REQ_TW-1:0]        req_tdata,   // [16:0] progress
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbe_pkg::RSP_TW-1:0]        rsp_tdata,   // [19:0] eased
   input  logic                              csr_we,
   input  logic [cbe_pkg::CSR_IW-1:0]        csr_index,
   input  logic [cbe_pkg::CSR_DW-1:0]        csr_wdata
);
   import cbe_pkg::*;

   localparam int MAXS = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
   localparam int CNW  = $clog2(MAXS + 1);
   localparam int DMW  = 19;             // magnitude of the clamped fraction
   localparam int SPW  = DMW + 24;       // reciprocal product

   typedef enum logic [3:0] {
      ST_FILL, ST_IDLE, ST_EVAL, ST_POST, ST_READ, ST_SCAN,
      ST_DIV, ST_NSTEP, ST_BMID, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PO_FILL, PO_CHECK, PO_NSLOPE, PO_NCURVE, PO_BISECT, PO_FINAL
   } post_type;

   typedef enum logic [1:0] {DP_DIST, DP_NEWTON} dpost_type;
   typedef enum logic [1:0] {EV_LEAD, EV_MID, EV_TAIL} step_type;

   // Configuration.
   logic [XW-1:0]        x1_ff, x2_ff;
   logic signed [YW-1:0] y1_ff, y2_ff;

   // Sequencer state.
   state_type         state_ff;
   post_type          post_ff;
   dpost_type         dpost_ff;
   step_type          step_ff;
   logic              issued_ff;
   logic              slope_ff;
   logic              sel_y_ff;
   logic [SIW-1:0]    fidx_ff, j_ff, seg_ff;
   logic [CNW-1:0]    n_ff;
   logic              div_go_ff;

   // Payload.
   t_type             t_ff, guess_ff, lo_ff, hi_ff, mid_ff;
   dw_type            acc_ff, sl_ff, dv_num_ff;
   logic signed [DVW-1:0] dv_den_ff;
   logic [XW-1:0]     x_ff, prev_ff, rdata_ff;
   logic signed [YW-1:0] y_ff;
   logic [XW-1:0]     samples_mem [SAMPLE_COUNT];

   // Combinational.
   logic signed [CW-1:0]  px1, px2, py1, py2, ax, bx, kx, ay, by, ky, ca, cb, cc;
   logic signed [MAW-1:0] mul_a;
   logic                  mul_start, mul_busy, mul_done;
   dw_type                mul_res;
   logic                  div_done;
   logic signed [QW-1:0]  div_quo;
   logic [XW-1:0]         prog;
   logic                  bypass, mem_we;
   dw_type                xq, cxv, den, num_dist, dist_c, qv, step_q;
   logic [DMW-1:0]        dist_mag, step_mag;
   logic [SPW-1:0]        step_prod;
   t_type                 guess_div, guess_newton, midc, seg_t;
   logic signed [TW:0]    span;
   logic [XW-1:0]         fill_val;
   logic signed [YW-1:0]  y_clamp;

   function automatic dw_type clamp_sym(dw_type v, dw_type lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   // Polynomial coefficients: a = 1 - 3 p2 + 3 p1, b = 3 p2 - 6 p1, c = 3 p1.
   always_comb begin
      px1 = CW'($signed({1'b0, x1_ff}));
      px2 = CW'($signed({1'b0, x2_ff}));
      py1 = CW'(y1_ff);
      py2 = CW'(y2_ff);
      ax  = CW'(CW'(ONE_Q) - CW'(3) * px2 + CW'(3) * px1);
      bx  = CW'(CW'(3) * px2 - CW'(6) * px1);
      kx  = CW'(CW'(3) * px1);
      ay  = CW'(CW'(ONE_Q) - CW'(3) * py2 + CW'(3) * py1);
      by  = CW'(CW'(3) * py2 - CW'(6) * py1);
      ky  = CW'(CW'(3) * py1);
      ca  = sel_y_ff ? ay : ax;
      cb  = sel_y_ff ? by : bx;
      cc  = sel_y_ff ? ky : kx;
   end

   // Horner form for x(t) and y(t); the slope is 3a t t + 2b t + c.
   always_comb begin
      unique case (step_ff)
         EV_LEAD: mul_a = slope_ff ? MAW'(ca) * MAW'(3) : MAW'(ca);
         EV_MID:  mul_a = slope_ff ? MAW'(acc_ff) : MAW'(acc_ff + DW'(cb));
         EV_TAIL: mul_a = slope_ff ? MAW'(cb) * MAW'(2) : MAW'(acc_ff + DW'(cc));
         default: mul_a = '0;
      endcase
      mul_start = (state_ff == ST_EVAL) && !issued_ff;
   end

   always_comb begin
      prog   = req_tdata[XW-1:0];
      bypass = (x1_ff > XW'(ONE_PROG)) || (x2_ff > XW'(ONE_PROG))
               || (($signed({3'b000, x1_ff}) == y1_ff) && ($signed({3'b000, x2_ff}) == y2_ff))
               || (prog == '0) || (prog == XW'(ONE_PROG));
      xq       = DW'($signed({1'b0, x_ff}));
      cxv      = acc_ff - xq;
      den      = DW'($signed({1'b0, rdata_ff})) - DW'($signed({1'b0, prev_ff}));
      num_dist = (xq - DW'($signed({1'b0, prev_ff}))) <<< FRAC_BITS;
      qv       = DW'(div_quo);
      dist_c   = clamp_sym(qv, DW'(DIST_LIM));
      // Fraction over the sample spacing count, truncated toward zero.
      dist_mag  = dist_c[DW-1] ? DMW'(-dist_c) : DMW'(dist_c);
      step_prod = SPW'(dist_mag) * SPW'(SEG_RECIP);
      step_mag  = DMW'(step_prod >> SEG_SHIFT);
      step_q    = dist_c[DW-1] ? -DW'(step_mag) : DW'(step_mag);
      guess_div = TW'(clamp_sym(DW'($signed(SAMPLE_T[seg_ff])) + step_q, DW'(T_LIM)));
      seg_t     = (j_ff == '0) ? '0 : t_type'(SAMPLE_T[SIW'(j_ff - 1'b1)]);
      guess_newton = TW'(clamp_sym(DW'(guess_ff) - clamp_sym(qv, DW'(CORR_LIM)),
                                   DW'(T_LIM)));
      span     = (TW+1)'(hi_ff) - (TW+1)'(lo_ff);
      midc     = TW'((TW+1)'(lo_ff) + (span >>> 1));
      if (acc_ff < 0) begin
         fill_val = '0;
      end else if (acc_ff > DW'(ONE_Q)) begin
         fill_val = XW'(ONE_Q);
      end else begin
         fill_val = acc_ff[XW-1:0];
      end
      y_clamp = YW'(clamp_sym(acc_ff, DW'(Y_LIM)));
      mem_we  = (state_ff == ST_POST) && (post_ff == PO_FILL);
   end

   cbe_qmul u_qmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (t_ff),
      .busy   (mul_busy),
      .done   (mul_done),
      .result (mul_res)
   );

   cbe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (dv_num_ff),
      .den   (dv_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sample table of x at the evenly spaced sample points.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         samples_mem[fidx_ff] <= fill_val;
      end
      rdata_ff <= samples_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FILL;
         post_ff   <= PO_FILL;
         dpost_ff  <= DP_DIST;
         step_ff   <= EV_LEAD;
         issued_ff <= 1'b0;
         slope_ff  <= 1'b0;
         sel_y_ff  <= 1'b0;
         fidx_ff   <= '0;
         j_ff      <= '0;
         seg_ff    <= '0;
         n_ff      <= '0;
         div_go_ff <= 1'b0;
         x1_ff     <= XW'(16384);
         y1_ff     <= YW'(6554);
         x2_ff     <= XW'(16384);
         y2_ff     <= YW'(65536);
      end else begin
         div_go_ff <= 1'b0;
         unique case (state_ff)
            ST_FILL: begin
               // Wait out any product still in flight from an abandoned pass.
               if (!mul_busy) begin
                  t_ff      <= t_type'(SAMPLE_T[fidx_ff]);
                  slope_ff  <= 1'b0;
                  sel_y_ff  <= 1'b0;
                  post_ff   <= PO_FILL;
                  step_ff   <= EV_LEAD;
                  issued_ff <= 1'b0;
                  state_ff  <= ST_EVAL;
               end
            end
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  x_ff <= prog;
                  if (bypass) begin
                     y_ff     <= YW'($signed({1'b0, prog}));
                     state_ff <= ST_OUT;
                  end else begin
                     j_ff     <= '0;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_EVAL: begin
               if (!issued_ff) begin
                  issued_ff <= 1'b1;
               end
               if (mul_done) begin
                  issued_ff <= 1'b0;
                  unique case (step_ff)
                     EV_LEAD: begin
                        acc_ff  <= mul_res;
                        step_ff <= EV_MID;
                     end
                     EV_MID: begin
                        acc_ff  <= mul_res;
                        step_ff <= EV_TAIL;
                     end
                     EV_TAIL: begin
                        acc_ff   <= slope_ff ? acc_ff + mul_res + DW'(cc) : mul_res;
                        state_ff <= ST_POST;
                     end
                     default: state_ff <= ST_POST;
                  endcase
               end
            end
            ST_POST: begin
               unique case (post_ff)
                  PO_FILL: begin
                     if (fidx_ff == SIW'(SAMPLE_COUNT - 1)) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        fidx_ff  <= fidx_ff + 1'b1;
                        state_ff <= ST_FILL;
                     end
                  end
                  PO_CHECK: begin
                     if (acc_ff >= DW'(MIN_SLOPE_Q)) begin
                        sl_ff    <= acc_ff;
                        n_ff     <= '0;
                        state_ff <= ST_NSTEP;
                     end else if (acc_ff == '0) begin
                        t_ff      <= guess_ff;
                        slope_ff  <= 1'b0;
                        sel_y_ff  <= 1'b1;
                        post_ff   <= PO_FINAL;
                        step_ff   <= EV_LEAD;
                        state_ff  <= ST_EVAL;
                     end else begin
                        lo_ff    <= t_type'(SAMPLE_T[seg_ff]);
                        hi_ff    <= t_type'(SAMPLE_T[SIW'(seg_ff + 1'b1)]);
                        n_ff     <= '0;
                        state_ff <= ST_BMID;
                     end
                  end
                  PO_NSLOPE: begin
                     sl_ff    <= acc_ff;
                     state_ff <= ST_NSTEP;
                  end
                  PO_NCURVE: begin
                     dv_num_ff <= cxv <<< FRAC_BITS;
                     dv_den_ff <= DVW'(sl_ff);
                     dpost_ff  <= DP_NEWTON;
                     div_go_ff <= 1'b1;
                     state_ff  <= ST_DIV;
                  end
                  PO_BISECT: begin
                     if (cxv > 0) begin
                        hi_ff <= mid_ff;
                     end else begin
                        lo_ff <= mid_ff;
                     end
                     n_ff <= CNW'(n_ff + 1'b1);
                     if ((cxv > DW'(PRECISION_Q) || cxv < -DW'(PRECISION_Q))
                         && (CNW'(n_ff + 1'b1) < CNW'(BISECT_STEPS))) begin
                        state_ff <= ST_BMID;
                     end else begin
                        t_ff     <= mid_ff;
                        slope_ff <= 1'b0;
                        sel_y_ff <= 1'b1;
                        post_ff  <= PO_FINAL;
                        step_ff  <= EV_LEAD;
                        state_ff <= ST_EVAL;
                     end
                  end
                  PO_FINAL: begin
                     y_ff     <= y_clamp;
                     state_ff <= ST_OUT;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_READ: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               // Walk the table to the last sample at or below x.
               if (j_ff == '0) begin
                  prev_ff  <= rdata_ff;
                  j_ff     <= SIW'(1);
                  state_ff <= ST_READ;
               end else if ((j_ff != SIW'(SAMPLE_COUNT - 1)) && (rdata_ff <= x_ff)) begin
                  prev_ff  <= rdata_ff;
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_READ;
               end else begin
                  seg_ff <= j_ff - 1'b1;
                  if (den == '0) begin
                     // Equal samples give a zero fraction: start at the sample point.
                     guess_ff <= seg_t;
                     t_ff     <= seg_t;
                     slope_ff <= 1'b1;
                     sel_y_ff <= 1'b0;
                     post_ff  <= PO_CHECK;
                     step_ff  <= EV_LEAD;
                     state_ff <= ST_EVAL;
                  end else begin
                     dv_num_ff <= num_dist;
                     dv_den_ff <= DVW'(den);
                     dpost_ff  <= DP_DIST;
                     div_go_ff <= 1'b1;
                     state_ff  <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  unique case (dpost_ff)
                     DP_DIST: begin
                        guess_ff <= guess_div;
                        t_ff     <= guess_div;
                        slope_ff <= 1'b1;
                        sel_y_ff <= 1'b0;
                        post_ff  <= PO_CHECK;
                        step_ff  <= EV_LEAD;
                        state_ff <= ST_EVAL;
                     end
                     DP_NEWTON: begin
                        guess_ff <= guess_newton;
                        t_ff     <= guess_newton;
                        n_ff     <= CNW'(n_ff + 1'b1);
                        step_ff  <= EV_LEAD;
                        state_ff <= ST_EVAL;
                        if (CNW'(n_ff + 1'b1) == CNW'(NEWTON_STEPS)) begin
                           slope_ff <= 1'b0;
                           sel_y_ff <= 1'b1;
                           post_ff  <= PO_FINAL;
                        end else begin
                           slope_ff <= 1'b1;
                           sel_y_ff <= 1'b0;
                           post_ff  <= PO_NSLOPE;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_NSTEP: begin
               t_ff     <= guess_ff;
               slope_ff <= 1'b0;
               step_ff  <= EV_LEAD;
               state_ff <= ST_EVAL;
               if (sl_ff == '0) begin
                  sel_y_ff <= 1'b1;
                  post_ff  <= PO_FINAL;
               end else begin
                  sel_y_ff <= 1'b0;
                  post_ff  <= PO_NCURVE;
               end
            end
            ST_BMID: begin
               mid_ff   <= midc;
               t_ff     <= midc;
               slope_ff <= 1'b0;
               sel_y_ff <= 1'b0;
               post_ff  <= PO_BISECT;
               step_ff  <= EV_LEAD;
               state_ff <= ST_EVAL;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // A register write rebuilds the sample table from the first entry.
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_X1:  x1_ff <= csr_wdata[XW-1:0];
               CSR_Y1:  y1_ff <= $signed(csr_wdata[YW-1:0]);
               CSR_X2:  x2_ff <= csr_wdata[XW-1:0];
               CSR_Y2:  y2_ff <= $signed(csr_wdata[YW-1:0]);
               default: x1_ff <= x1_ff;
            endcase
            fidx_ff   <= '0;
            issued_ff <= 1'b0;
            state_ff  <= ST_FILL;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !csr_we;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {{(RSP_TW - YW){1'b0}}, y_ff};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in progress");

   a_hold_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready raised while a response waits");

   a_write_rebuilds: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("ready raised before the sample table was rebuilt");

   a_eased_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[YW-1:0]) <= $signed(YW'(Y_LIM))
                      && $signed(rsp_tdata[YW-1:0]) >= -$signed(YW'(Y_LIM))))
      else $error("eased value outside the clamp range");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the cubic Bezier easing unit: drives progress requests,
// predicts each eased value in fixed point and checks every response in order.
// Depends on cbe_pkg and cubic_bezier_easing_unit.
`timescale 1ns / 1ps

module testbench;
   import cbe_pkg::*;

   localparam longint LIMIT_CYCLES = 4000000;

   typedef struct {
      logic [XW-1:0] progress;
      logic [YW-1:0] eased;
   } eased_exp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TW-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = CSR_X1;
   logic [CSR_DW-1:0] csr_wdata = '0;

   logic [XW-1:0] progress_pending[$];
   eased_exp_type eased_expected[$];
   int  mismatch_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   longint cycle_count = 0;

   // Predictor state: Q16 control points and the x sample table.
   longint pr_x1, pr_y1, pr_x2, pr_y2;
   longint pr_samples[SAMPLE_COUNT];

   cubic_bezier_easing_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic longint round_shift(longint v, int k);
      longint h;
      if (k == 0) return v;
      h = 64'sd1 <<< (k - 1);
      if (v >= 0) return (v + h) >>> k;
      return -((-v + h) >>> k);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return round_shift(a * b, FRAC_BITS);
   endfunction

   function automatic longint fx_div(longint num, longint den);
      return (num * ONE_Q) / den;
   endfunction

   function automatic longint grid_t(longint i);
      return (i * ONE_Q + (SAMPLE_COUNT - 1) / 2) / (SAMPLE_COUNT - 1);
   endfunction

   function automatic longint bezier_at(longint t, longint p1, longint p2);
      longint a, b, c;
      a = ONE_Q - 3 * p2 + 3 * p1;
      b = 3 * p2 - 6 * p1;
      c = 3 * p1;
      return fx_mul(fx_mul(fx_mul(a, t) + b, t) + c, t);
   endfunction

   function automatic longint bezier_slope(longint t, longint p1, longint p2);
      longint a, b, c;
      a = ONE_Q - 3 * p2 + 3 * p1;
      b = 3 * p2 - 6 * p1;
      c = 3 * p1;
      return fx_mul(fx_mul(3 * a, t), t) + fx_mul(2 * b, t) + c;
   endfunction

   function automatic void rebuild_samples();
      for (int i = 0; i < SAMPLE_COUNT; i++)
         pr_samples[i] = clip(bezier_at(grid_t(i), pr_x1, pr_x2), 0, ONE_Q);
   endfunction

   // Inverts x(t): table search, interpolated guess, Newton or bisection unless s == 0.
   function automatic longint invert_x(longint x);
      longint den, offset, guess, s, sl, lo, hi, mid, cx;
      int i, n;
      offset = 0;
      mid = 0;
      i = 1;
      while (i != SAMPLE_COUNT - 1 && pr_samples[i] <= x) i++;
      i--;
      den = pr_samples[i + 1] - pr_samples[i];
      if (den != 0) offset = clip(fx_div(x - pr_samples[i], den), -DIST_LIM, DIST_LIM);
      guess = clip(grid_t(i) + offset / (SAMPLE_COUNT - 1), -T_LIM, T_LIM);
      s = bezier_slope(guess, pr_x1, pr_x2);
      if (s >= MIN_SLOPE_Q) begin
         for (n = 0; n < NEWTON_STEPS_DEF; n++) begin
            sl = bezier_slope(guess, pr_x1, pr_x2);
            if (sl == 0) return guess;
            cx = bezier_at(guess, pr_x1, pr_x2) - x;
            guess -= clip(fx_div(cx, sl), -CORR_LIM, CORR_LIM);
            guess = clip(guess, -T_LIM, T_LIM);
         end
         return guess;
      end
      if (s == 0) return guess;
      lo = grid_t(i);
      hi = grid_t(i + 1);
      n = 0;
      do begin
         mid = lo + ((hi - lo) >>> 1);
         cx = bezier_at(mid, pr_x1, pr_x2) - x;
         if (cx > 0) hi = mid; else lo = mid;
         n++;
      end while ((cx > PRECISION_Q || cx < -PRECISION_Q) && n < BISECT_STEPS_DEF);
      return mid;
   endfunction

   function automatic logic [YW-1:0] predict_eased(logic [XW-1:0] progress);
      longint p, y;
      p = longint'(progress);
      if (pr_x1 > 65536 || pr_x2 > 65536 || (pr_x1 == pr_y1 && pr_x2 == pr_y2) ||
          p == 0 || p == ONE_PROG) begin
         y = p;
      end else begin
         y = round_shift(bezier_at(invert_x(p), pr_y1, pr_y2), FRAC_BITS - 16);
         y = clip(y, -Y_LIM, Y_LIM);
      end
      return y[YW-1:0];
   endfunction

   task automatic report_mismatch(logic [XW-1:0] progress, logic [YW-1:0] got,
                                  logic [YW-1:0] want, string what);
      $display("MISMATCH %s: progress %0d got %0d expected %0d", what, progress,
               $signed(got), $signed(want));
      mismatch_count++;
   endtask

   // Request driver: one nonblocking update of req_tvalid per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            eased_expected.push_back('{req_tdata[XW-1:0], predict_eased(req_tdata[XW-1:0])});
         if (!req_tvalid || req_tready) begin
            if (progress_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {{(REQ_TW - XW){1'b0}}, progress_pending.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver back-pressure.
   always @(posedge clock) begin
      eased_exp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (eased_expected.size() == 0) begin
               report_mismatch('0, rsp_tdata[YW-1:0], '0, "unexpected response");
            end else begin
               e = eased_expected.pop_front();
               if (rsp_tdata[YW-1:0] !== e.eased)
                  report_mismatch(e.progress, rsp_tdata[YW-1:0], e.eased, "eased");
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_X1: pr_x1 = longint'(value[XW-1:0]);
         CSR_Y1: pr_y1 = longint'($signed(value[YW-1:0]));
         CSR_X2: pr_x2 = longint'(value[XW-1:0]);
         default: pr_y2 = longint'($signed(value[YW-1:0]));
      endcase
      rebuild_samples();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_curve(longint x1, longint y1, longint x2, longint y2);
      write_reg(CSR_X1, x1[CSR_DW-1:0]);
      write_reg(CSR_Y1, y1[CSR_DW-1:0]);
      write_reg(CSR_X2, x2[CSR_DW-1:0]);
      write_reg(CSR_Y2, y2[CSR_DW-1:0]);
   endtask

   task automatic drain();
      while (progress_pending.size() > 0 || req_tvalid || eased_expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [XW-1:0] rand_progress();
      case ($urandom_range(9))
         0: return XW'($urandom_range(3));
         1: return XW'(65536 - $urandom_range(3));
         default: return XW'($urandom_range(65536));
      endcase
   endfunction

   function automatic longint rand_y();
      if ($urandom_range(4) == 0) return $urandom_range(1) ? Y_LIM : -Y_LIM;
      return longint'($urandom_range(524288)) - Y_LIM;
   endfunction

   initial begin
      longint x1, y1, x2, y2;
      logic [XW-1:0] directed[$];
      pr_x1 = 16384; pr_y1 = 6554; pr_x2 = 16384; pr_y2 = 65536;
      rebuild_samples();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: ends, near-ends, single bits and the reset curve.
      directed = '{0, 65536, 1, 65535, 32768, 21845, 43690, 2, 16384, 49152, 6553, 58982};
      foreach (directed[k]) progress_pending.push_back(directed[k]);
      drain();
      set_curve(30000, 30000, 50000, 50000);         // linear curve
      progress_pending.push_back(12345);
      progress_pending.push_back(65000);
      drain();
      set_curve(0, -Y_LIM, 65536, Y_LIM);            // extreme control points
      progress_pending.push_back(1000);
      progress_pending.push_back(64000);
      progress_pending.push_back(30000);
      drain();
      set_curve(65536, Y_LIM, 0, -Y_LIM);
      progress_pending.push_back(500);
      progress_pending.push_back(33000);
      drain();
      set_curve(131071, 100, 200, 300);              // x out of range, upper bits set
      write_reg(CSR_X1, 20'hFFFFF);
      progress_pending.push_back(40000);
      drain();
      set_curve(0, 65536, 0, 0);                     // flat x start, slope near zero
      progress_pending.push_back(3);
      progress_pending.push_back(100);
      progress_pending.push_back(60000);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         case ($urandom_range(5))
            0: begin x1 = 0; x2 = 65536; end
            1: begin x1 = $urandom_range(2000); x2 = $urandom_range(2000); end
            2: begin x1 = 65536 - $urandom_range(2000); x2 = 65536 - $urandom_range(2000); end
            default: begin x1 = $urandom_range(65536); x2 = $urandom_range(65536); end
         endcase
         y1 = rand_y();
         y2 = rand_y();
         set_curve(x1, y1, x2, y2);
         for (int k = 0; k < 150; k++) progress_pending.push_back(rand_progress());
         if (ph == 4) begin
            // Long receiver hold-off while requests keep coming.
            send_idle_pct = 0;
            hold_requests++;
         end
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && eased_expected.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/cbe_pkg.sv
hw/rtl/cbe_qmul.sv
hw/rtl/cbe_div.sv
hw/rtl/cubic_bezier_easing_unit.sv
tb/testbench.sv
